FILE: hdl/wmmf_pkg.sv
// shared types and constants of the windowed minimum filter
`timescale 1ns / 1ps
package wmmf_pkg;

	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 2;
	localparam int INDEX_W = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS = 2'd2;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_BASE,
		S_SCAN,
		S_DRAIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic setup;
		logic base;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic emit_req;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

FILE: hdl/wmmf_if.sv
// stream interfaces for pixel input and result output
`timescale 1ns / 1ps
interface wmmf_in_if #(parameter int PIXEL_BITS = 16);
	logic valid;
	logic ready;
	logic cmd;
	logic signed [PIXEL_BITS-1:0] pixel_value;
	modport source (output valid, cmd, pixel_value, input ready);
	modport sink (input valid, cmd, pixel_value, output ready);
endinterface

interface wmmf_out_if #(parameter int PIXEL_BITS = 16);
	logic valid;
	logic ready;
	logic signed [PIXEL_BITS-1:0] min_value;
	logic [19:0] min_index;
	logic frame_last;
	modport source (output valid, min_value, min_index, frame_last, input ready);
	modport sink (input valid, min_value, min_index, frame_last, output ready);
endinterface

FILE: hdl/wmmf_ctrl.sv
// controller state machine sequencing accept, window scan and result
`timescale 1ns / 1ps
module wmmf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  wmmf_pkg::dp_status_t st,
	output logic                in_ready,
	output wmmf_pkg::ctrl_cmd_t cmd,
	output wmmf_pkg::state_t    state
);
	import wmmf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.emit_req) begin
						state_d = S_SETUP;
					end
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d = S_BASE;
			end
			S_BASE: begin
				cmd.base = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

FILE: hdl/wmmf_datapath.sv
// counters, line store, window scan and result register
`timescale 1ns / 1ps
module wmmf_datapath #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 7,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [wmmf_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [wmmf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_cmd,
	input  logic signed [PIXEL_BITS-1:0]          in_pixel,
	input  logic                                  out_ready,
	input  wmmf_pkg::ctrl_cmd_t                   cmd,
	output wmmf_pkg::dp_status_t                  st,
	output logic                                  out_valid,
	output logic signed [PIXEL_BITS-1:0]          out_value,
	output logic [wmmf_pkg::INDEX_W-1:0]          out_index,
	output logic                                  out_last
);
	import wmmf_pkg::*;

	localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int TW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
	localparam logic [AW:0] DEPTH_X = (AW + 1)'(DEPTH);

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [RW-1:0] r_q;
	logic [TW-1:0] n_q, lag_q;
	logic [CW-1:0] pr_q, oe_q;
	logic [AW-1:0] wr_addr_q, oaddr_q;
	logic [WW-1:0] ox_q;
	logic [HW-1:0] oy_q;

	logic signed [PIXEL_BITS-1:0] mem [DEPTH];
	logic signed [PIXEL_BITS-1:0] rdata_s1;
	logic [AW-1:0] raddr;

	logic [RW:0] rows_m1_q, cols_m1_q, ri_q, ci_q;
	logic [AW-1:0] off_s1;
	logic [AW-1:0] cur_addr_q, row_addr_q;
	logic [CW-1:0] cur_j_q, row_j_q;
	logic rd_v_s1;
	logic [CW-1:0] j_s1;
	logic signed [PIXEL_BITS-1:0] best_q;
	logic [CW-1:0] best_idx_q;

	logic [WW-1:0] w_new;
	logic [HW-1:0] h_new;
	logic [RW-1:0] r_new;
	logic full, more, last_out;
	logic cfg_hit;
	logic [TW-1:0] pr_x, oe_x;

	// saturated register values
	always_comb begin
		int d;
		d = int'(cfg_data);
		if (d == 0) w_new = WW'(1);
		else if (d > MAX_WIDTH) w_new = WW'(MAX_WIDTH);
		else w_new = WW'(d);
		if (d == 0) h_new = HW'(1);
		else if (d > MAX_HEIGHT) h_new = HW'(MAX_HEIGHT);
		else h_new = HW'(d);
		if (cfg_data[2:0] == 3'd0) r_new = RW'(1);
		else if (int'(cfg_data[2:0]) > MAX_RADIUS) r_new = RW'(MAX_RADIUS);
		else r_new = RW'(cfg_data[2:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
			h_q <= HW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
			r_q <= RW'(MAX_RADIUS < 3 ? MAX_RADIUS : 3);
			n_q <= TW'((MAX_WIDTH < 1024 ? MAX_WIDTH : 1024) *
				(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024));
			lag_q <= TW'((MAX_RADIUS < 3 ? MAX_RADIUS : 3) *
				((MAX_WIDTH < 1024 ? MAX_WIDTH : 1024) + 1) + 1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					w_q <= w_new;
					n_q <= TW'(w_new) * TW'(h_q);
					lag_q <= TW'(r_q) * (TW'(w_new) + TW'(1)) + TW'(1);
				end
				REG_HEIGHT: begin
					h_q <= h_new;
					n_q <= TW'(w_q) * TW'(h_new);
				end
				REG_RADIUS: begin
					r_q <= r_new;
					lag_q <= TW'(r_new) * (TW'(w_q) + TW'(1)) + TW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// only a known register restarts the frame
	assign cfg_hit = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_RADIUS);

	assign pr_x = TW'(pr_q);
	assign oe_x = TW'(oe_q);
	assign full = pr_x >= n_q;
	assign more = oe_x < n_q;
	assign last_out = (oe_x + TW'(1)) >= n_q;

	always_comb begin
		if (full) st.emit_req = more;
		else st.emit_req = (in_cmd == CMD_PUSH) && more && (pr_x + TW'(1) >= oe_x + lag_q);
	end

	assign st.scan_last = (ci_q == cols_m1_q) && (ri_q == rows_m1_q);
	assign st.out_free = !out_valid || out_ready;

	// frame counters and output position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_q <= '0;
			oe_q <= '0;
			wr_addr_q <= '0;
			oaddr_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
		end else if (cfg_hit || (cmd.accept && full && !more) || (cmd.finish && last_out)) begin
			pr_q <= '0;
			oe_q <= '0;
			wr_addr_q <= '0;
			oaddr_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
		end else begin
			if (cmd.accept && !full && in_cmd == CMD_PUSH) begin
				pr_q <= pr_q + CW'(1);
				wr_addr_q <= (int'(wr_addr_q) == DEPTH - 1) ? '0 : wr_addr_q + AW'(1);
			end
			if (cmd.finish) begin
				oe_q <= oe_q + CW'(1);
				oaddr_q <= (int'(oaddr_q) == DEPTH - 1) ? '0 : oaddr_q + AW'(1);
				if (ox_q == w_q - WW'(1)) begin
					ox_q <= '0;
					oy_q <= oy_q + HW'(1);
				end else begin
					ox_q <= ox_q + WW'(1);
				end
			end
		end
	end

	// line store
	assign raddr = cmd.setup ? oaddr_q : cur_addr_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && !full && in_cmd == CMD_PUSH) begin
			mem[wr_addr_q] <= in_pixel;
		end
		rdata_s1 <= mem[raddr];
	end

	// window geometry and scan walk
	always_ff @(posedge clk) begin
		int y, x, r, w, h, dyl, dyh, dxl, dxh;
		logic [AW:0] t;
		logic [AW:0] nrow;
		y = int'(oy_q);
		x = int'(ox_q);
		r = int'(r_q);
		w = int'(w_q);
		h = int'(h_q);
		dyl = (y < r) ? y : r;
		dyh = (h - 1 - y < r) ? h - 1 - y : r;
		dxl = (x < r) ? x : r;
		dxh = (w - 1 - x < r) ? w - 1 - x : r;
		t = {1'b0, oaddr_q} - {1'b0, off_s1};
		nrow = {1'b0, row_addr_q} + (AW + 1)'(w_q);
		if (cmd.setup) begin
			rows_m1_q <= (RW + 1)'(dyl + dyh);
			cols_m1_q <= (RW + 1)'(dxl + dxh);
			off_s1 <= AW'(dyl * w + dxl);
		end
		if (cmd.base) begin
			if (t[AW]) t = t + DEPTH_X;
			row_addr_q <= t[AW-1:0];
			cur_addr_q <= t[AW-1:0];
			row_j_q <= oe_q - CW'(off_s1);
			cur_j_q <= oe_q - CW'(off_s1);
			ri_q <= '0;
			ci_q <= '0;
		end
		if (cmd.scan) begin
			if (ci_q == cols_m1_q) begin
				if (nrow >= DEPTH_X) nrow = nrow - DEPTH_X;
				ci_q <= '0;
				ri_q <= ri_q + (RW + 1)'(1);
				row_addr_q <= nrow[AW-1:0];
				cur_addr_q <= nrow[AW-1:0];
				row_j_q <= row_j_q + CW'(w_q);
				cur_j_q <= row_j_q + CW'(w_q);
			end else begin
				ci_q <= ci_q + (RW + 1)'(1);
				cur_addr_q <= (int'(cur_addr_q) == DEPTH - 1) ? '0 : cur_addr_q + AW'(1);
				cur_j_q <= cur_j_q + CW'(1);
			end
		end
		j_s1 <= cur_j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan;
		end
	end

	// running minimum, centre first
	always_ff @(posedge clk) begin
		if (cmd.base) begin
			best_q <= rdata_s1;
			best_idx_q <= oe_q;
		end else if (rd_v_s1 && (rdata_s1 < best_q)) begin
			best_q <= rdata_s1;
			best_idx_q <= j_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_value <= best_q;
			out_index <= INDEX_W'(best_idx_q);
			out_last <= last_out;
		end
	end

endmodule

FILE: hdl/windowed_min_argmin_filter.sv
// top level of the windowed minimum and arg-minimum filter
// an item that completes a window starts setup, base, scan, drain and output in turn
// throughput: one item per cycle when no result is due, else none until it is loaded
// the scan walks the clipped window, at most (2*radius+1)^2, one line store read a cycle
// reset clears counters and control; registers return to width 1024, height 1024, radius 3
// the line store is not cleared; only pixels of the current frame are read
`timescale 1ns / 1ps
module windowed_min_argmin_filter #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 7,
	parameter int PIXEL_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wmmf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wmmf_pkg::CFG_DATA_W-1:0]  cfg_data,
	wmmf_in_if.sink                          px_in,
	wmmf_out_if.source                       res_out
);
	import wmmf_pkg::*;

	ctrl_cmd_t cmd;
	dp_status_t st;
	state_t state;

	wmmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (px_in.valid),
		.st       (st),
		.in_ready (px_in.ready),
		.cmd      (cmd),
		.state    (state)
	);

	wmmf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_cmd    (px_in.cmd),
		.in_pixel  (px_in.pixel_value),
		.out_ready (res_out.ready),
		.cmd       (cmd),
		.st        (st),
		.out_valid (res_out.valid),
		.out_value (res_out.min_value),
		.out_index (res_out.min_index),
		.out_last  (res_out.frame_last)
	);

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free) else $error("result loaded over a pending transfer");

	a_emit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && st.emit_req) |=> (state == S_SETUP))
		else $error("due result did not start a window scan");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && st.scan_last) |=> (state == S_DRAIN))
		else $error("window scan did not end on its last read");

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the windowed minimum and arg-minimum filter
`timescale 1ns / 1ps
module testbench;
	import wmmf_pkg::*;

	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam int MAXR = 7;
	localparam int STORE_DEPTH = (2 * MAXR + 1) * MAXW;
	localparam int SETTLE = 300;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic cmd;
		logic signed [15:0] value;
	} pixel_item_t;

	typedef struct {
		logic signed [15:0] min_value;
		logic [19:0] min_index;
		logic frame_last;
	} window_min_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wmmf_in_if #(.PIXEL_BITS(16)) px_in ();
	wmmf_out_if #(.PIXEL_BITS(16)) res_out ();

	windowed_min_argmin_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.px_in(px_in),
		.res_out(res_out)
	);

	pixel_item_t pixel_queue[$];
	window_min_t expected_mins[$];
	logic signed [15:0] frame_store[STORE_DEPTH];
	int unsigned rcvd_count;
	int unsigned emit_count;
	logic [10:0] reg_width;
	logic [10:0] reg_height;
	logic [2:0] reg_radius;
	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int random_items;
	bit pixel_taken;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_reg(int v, int hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic void emit_window_min();
		int w, h, r, n, y, x, y0, y1, x0, x1;
		int unsigned best_idx, j;
		logic signed [15:0] best;
		window_min_t res;
		w = clamp_reg(reg_width, MAXW);
		h = clamp_reg(reg_height, MAXH);
		r = clamp_reg(reg_radius, MAXR);
		n = w * h;
		y = emit_count / w;
		x = emit_count % w;
		y0 = (y - r < 0) ? 0 : y - r;
		x0 = (x - r < 0) ? 0 : x - r;
		y1 = (y + r > h - 1) ? h - 1 : y + r;
		x1 = (x + r > w - 1) ? w - 1 : x + r;
		best = frame_store[emit_count % STORE_DEPTH];
		best_idx = emit_count;
		for (int yy = y0; yy <= y1; yy++)
			for (int xx = x0; xx <= x1; xx++) begin
				j = yy * w + xx;
				if (frame_store[j % STORE_DEPTH] < best) begin
					best = frame_store[j % STORE_DEPTH];
					best_idx = j;
				end
			end
		res.min_value = best;
		res.min_index = best_idx[19:0];
		emit_count++;
		res.frame_last = (emit_count >= n);
		if (emit_count >= n) begin
			rcvd_count = 0;
			emit_count = 0;
		end
		expected_mins.push_back(res);
	endfunction

	function automatic void predict_pixel(pixel_item_t it);
		int w, r, n;
		w = clamp_reg(reg_width, MAXW);
		r = clamp_reg(reg_radius, MAXR);
		n = w * clamp_reg(reg_height, MAXH);
		if (rcvd_count >= n) begin
			if (emit_count < n)
				emit_window_min();
			else begin
				rcvd_count = 0;
				emit_count = 0;
			end
			return;
		end
		if (it.cmd == CMD_FLUSH)
			return;
		frame_store[rcvd_count % STORE_DEPTH] = it.value;
		rcvd_count++;
		if (emit_count < n && rcvd_count >= emit_count + r * w + r + 1)
			emit_window_min();
	endfunction

	// monitor: transfers sampled at the rising edge
	always @(posedge clk) begin
		window_min_t exp_res;
		pixel_taken = 1'b0;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
			if (res_out.valid && res_out.ready) begin
				if (expected_mins.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result value %0d index %0d last %0b",
							res_out.min_value, res_out.min_index, res_out.frame_last);
				end else begin
					exp_res = expected_mins.pop_front();
					if (res_out.min_value !== exp_res.min_value ||
						res_out.min_index !== exp_res.min_index ||
						res_out.frame_last !== exp_res.frame_last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
								exp_res.min_value, exp_res.min_index, exp_res.frame_last,
								res_out.min_value, res_out.min_index, res_out.frame_last);
					end
				end
			end
			if (px_in.valid && px_in.ready) begin
				pixel_taken = 1'b1;
				predict_pixel('{px_in.cmd, px_in.pixel_value});
			end
		end
	end

	// driver: inputs change at the falling edge
	always @(negedge clk) begin
		pixel_item_t it;
		if (arst_n) begin
			if (!px_in.valid || pixel_taken) begin
				if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					it = pixel_queue.pop_front();
					px_in.valid <= 1'b1;
					px_in.cmd <= it.cmd;
					px_in.pixel_value <= it.value;
				end else
					px_in.valid <= 1'b0;
			end
			res_out.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [10:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_WIDTH)
			reg_width = val;
		else if (idx == REG_HEIGHT)
			reg_height = val;
		else if (idx == REG_RADIUS)
			reg_radius = val[2:0];
		rcvd_count = 0;
		emit_count = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		wait (pixel_queue.size() == 0 && !px_in.valid && expected_mins.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(int w, int h, int r);
		wait_idle();
		write_reg(REG_WIDTH, w[10:0]);
		write_reg(REG_HEIGHT, h[10:0]);
		write_reg(REG_RADIUS, r[10:0]);
	endtask

	function automatic logic signed [15:0] random_pixel();
		case ($urandom_range(3))
			0: return 16'($urandom_range(4) - 2);
			1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom());
		endcase
	endfunction

	// one frame with random content: stray flushes while filling, mixed drain items
	task automatic queue_frame(bit counted);
		int w, h, r, n, drains;
		w = clamp_reg(reg_width, MAXW);
		h = clamp_reg(reg_height, MAXH);
		r = clamp_reg(reg_radius, MAXR);
		n = w * h;
		drains = (n - r * w - r > 0) ? r * w + r : n;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				pixel_queue.push_back('{CMD_FLUSH, random_pixel()});
			pixel_queue.push_back('{CMD_PUSH, random_pixel()});
		end
		for (int i = 0; i < drains; i++)
			pixel_queue.push_back('{$urandom_range(1) ? CMD_FLUSH : CMD_PUSH, random_pixel()});
		if (counted)
			random_items += n + drains;
	endtask

	initial begin
		logic signed [15:0] corner_vals[12];
		corner_vals = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0005, -16'sh0001,
			-16'sh0001, 16'sh0007, 16'sh7fff, 16'sh8000, 16'sh0003, 16'sh0003};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		px_in.valid = 1'b0;
		px_in.cmd = CMD_PUSH;
		px_in.pixel_value = '0;
		res_out.ready = 1'b0;
		reg_width = 11'd1024;
		reg_height = 11'd1024;
		reg_radius = 3'd3;
		rcvd_count = 0;
		emit_count = 0;
		mismatches = 0;
		random_items = 0;
		cycles = 0;
		send_idle_pct = 38;
		recv_idle_pct = 85;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// small frame with extremes and ties
		configure(4, 3, 1);
		pixel_queue.push_back('{CMD_FLUSH, 16'sh1234});
		foreach (corner_vals[i])
			pixel_queue.push_back('{CMD_PUSH, corner_vals[i]});
		for (int i = 0; i < 5; i++)
			pixel_queue.push_back('{i[0] ? CMD_PUSH : CMD_FLUSH, 16'sh7fff});
		// zero registers act as one pixel, radius one
		configure(0, 0, 0);
		queue_frame(0);
		queue_frame(0);

		while (random_items < 750) begin
			if (random_items < 250) begin
				send_idle_pct = 38;
				recv_idle_pct = 85;
			end else if (random_items < 500) begin
				send_idle_pct = 85;
				recv_idle_pct = 38;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure($urandom_range(12, 1), $urandom_range(8, 1), $urandom_range(7, 1));
			repeat ($urandom_range(2, 1))
				queue_frame(1);
		end

		wait_idle();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
